// File: sv/hmdp_pkg.sv
// Shared constants, types and decode helpers for the HID mouse descriptor parser.
`default_nettype none
package hmdp_pkg;

   // Byte-parser phases
   typedef enum logic [2:0] {
      PH_PREFIX    = 3'd0,
      PH_SHORT     = 3'd1,
      PH_LONG_LEN  = 3'd2,
      PH_LONG_TAG  = 3'd3,
      PH_LONG_SKIP = 3'd4
   } phase_type;

   // Item types and tags
   localparam logic [1:0] TYPE_MAIN   = 2'd0;
   localparam logic [1:0] TYPE_GLOBAL = 2'd1;
   localparam logic [1:0] TYPE_LOCAL  = 2'd2;

   localparam logic [3:0] TAG_INPUT       = 4'h8;
   localparam logic [3:0] TAG_USAGE_PAGE  = 4'h0;
   localparam logic [3:0] TAG_REPORT_SIZE = 4'h7;
   localparam logic [3:0] TAG_REPORT_ID   = 4'h8;
   localparam logic [3:0] TAG_REPORT_CNT  = 4'h9;
   localparam logic [3:0] TAG_USAGE       = 4'h0;
   localparam logic [3:0] TAG_USAGE_MIN   = 4'h1;
   localparam logic [3:0] TAG_USAGE_MAX   = 4'h2;
   localparam logic [3:0] LONG_NIBBLE     = 4'hF;

   localparam logic [15:0] PAGE_DESKTOP = 16'h0001;
   localparam logic [15:0] PAGE_BUTTON  = 16'h0009;
   localparam logic [15:0] USAGE_X      = 16'h0030;
   localparam logic [15:0] USAGE_Y      = 16'h0031;
   localparam logic [15:0] USAGE_WHEEL  = 16'h0038;

   // Field slots: buttons, X, Y, wheel
   localparam logic [1:0] SLOT_BTN   = 2'd0;
   localparam logic [1:0] SLOT_X     = 2'd1;
   localparam logic [1:0] SLOT_Y     = 2'd2;
   localparam logic [1:0] SLOT_WHEEL = 2'd3;

   // Data length of a short item from its size code
   function automatic logic [2:0] short_len(input logic [7:0] prefix);
      return (prefix[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix[1:0]};
   endfunction

   // Axis slot of a desktop usage, SLOT_BTN when not an axis
   function automatic logic [1:0] axis_of(input logic [15:0] usage);
      logic [1:0] k;
      k = SLOT_BTN;
      if (usage == USAGE_X) k = SLOT_X;
      if (usage == USAGE_Y) k = SLOT_Y;
      if (usage == USAGE_WHEEL) k = SLOT_WHEEL;
      return k;
   endfunction

   // Usage searched for in range step t (0 X, 1 Y, 2 wheel)
   function automatic logic [15:0] range_target(input logic [1:0] t);
      logic [15:0] u;
      case (t)
         2'd0:    u = USAGE_X;
         2'd1:    u = USAGE_Y;
         default: u = USAGE_WHEEL;
      endcase
      return u;
   endfunction

endpackage
`default_nettype wire

// File: sv/hmdp_ifs.sv
// Request and response channel interfaces of the descriptor parser.
`default_nettype none
interface hmdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] desc_byte;
   logic       last_byte;
   modport source (output valid, output desc_byte, output last_byte, input ready);
   modport sink   (input valid, input desc_byte, input last_byte, output ready);
endinterface

interface hmdp_rsp_if;
   logic        valid;
   logic        ready;
   logic        format_valid;
   logic [7:0]  rpt_id;
   logic [15:0] button_offset;
   logic [15:0] button_bits;
   logic [15:0] x_offset;
   logic [7:0]  x_bits;
   logic [15:0] y_offset;
   logic [7:0]  y_bits;
   logic [15:0] wheel_offset;
   logic [7:0]  wheel_width;
   logic [2:0]  signed_flags;
   modport source (output valid, output format_valid, output rpt_id,
                   output button_offset, output button_bits, output x_offset,
                   output x_bits, output y_offset, output y_bits,
                   output wheel_offset, output wheel_width, output signed_flags,
                   input ready);
   modport sink   (input valid, input format_valid, input rpt_id,
                   input button_offset, input button_bits, input x_offset,
                   input x_bits, input y_offset, input y_bits,
                   input wheel_offset, input wheel_width, input signed_flags,
                   output ready);
endinterface
`default_nettype wire

// File: sv/hid_mouse_descriptor_parser_core.sv
// Top level: HID report descriptor parser that extracts the mouse report layout.
//
//   channel   | dir | handshake     | payload
//   req_chan  | in  | valid/ready   | desc_byte, last_byte
//   rsp_chan  | out | valid/ready   | format_valid, rpt_id, offsets, widths, signs
//
// One request per cycle while an item is still being collected; a request that ends an
// item then runs it in S_EXEC before the next is taken. An Input item advances the offset
// in S_ADV and S_ADV2; on the desktop page it first reads and compares each stored usage
// (S_RD, S_CHK), ends the scan in S_RD, and searches a usage range in S_RNG and S_RNG2.
// The last byte forms the result in S_FINAL, which then holds until taken.
// Reset is synchronous; the usage memory needs no clearing since only filled slots are read.
// req ready is low while an item executes or a response waits.
`default_nettype none
module hid_mouse_descriptor_parser_core #(
   parameter int USAGE_SLOTS  = 16,
   parameter int OFFSET_WIDTH = 16
) (
   input  wire         clock,
   input  wire         reset,
   hmdp_req_if.sink    req_chan,
   hmdp_rsp_if.source  rsp_chan
);
   import hmdp_pkg::*;

   localparam int IW = (USAGE_SLOTS > 1) ? $clog2(USAGE_SLOTS) : 1;
   localparam int FW = $clog2(USAGE_SLOTS + 1);
   localparam int OW = OFFSET_WIDTH;
   localparam int SW = ((OW > 24) ? OW : 24) + 1;
   localparam logic [SW-1:0] OFF_MAX = (SW'(1) << OW) - SW'(1);
   localparam logic [FW-1:0] SLOTS_F = FW'(USAGE_SLOTS);

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_RD, S_CHK, S_RNG, S_RNG2, S_ADV, S_ADV2, S_FINAL, S_OUT
   } state_type;

   function automatic logic [SW-1:0] sat(input logic [SW-1:0] v);
      return (v > OFF_MAX) ? OFF_MAX : v;
   endfunction

   state_type        state_ff;
   phase_type        phase_ff;
   logic [7:0]       prefix_ff;
   logic [31:0]      data_ff;
   logic [7:0]       remain_ff;
   logic [OW-1:0]    run_ff;
   logic [7:0]       size_ff;
   logic [15:0]      count_ff;
   logic [15:0]      page_ff;
   logic [FW-1:0]    fill_ff;
   logic [15:0]      rstart_ff;
   logic             rseen_ff;
   logic [3:0]       found_ff;
   logic [7:0]       rid_ff;
   logic [OW-1:0]    off_ff [4];
   logic [15:0]      btn_bits_ff;
   logic [7:0]       ax_bits_ff [4];
   logic [2:0]       sign_ff;
   logic             last_ff;
   logic [FW-1:0]    u_ff;
   logic [SW-1:0]    acc_ff;
   logic [1:0]       t_ff;
   logic             idx_ok_ff;
   logic [23:0]      prod_ff;
   logic [15:0]      rd_ff;
   logic [15:0]      usage_mem [USAGE_SLOTS];

   logic             rsp_valid_ff;
   logic             rsp_fmt_ff;
   logic [7:0]       rsp_rid_ff;
   logic [15:0]      rsp_off_ff [4];
   logic [15:0]      rsp_bbits_ff;
   logic [7:0]       rsp_xbits_ff;
   logic [7:0]       rsp_ybits_ff;
   logic [7:0]       rsp_wbits_ff;
   logic [2:0]       rsp_sign_ff;

   // Byte parser next values
   phase_type        phase_in;
   logic [7:0]       prefix_in;
   logic [31:0]      data_in;
   logic [7:0]       remain_in;
   logic             finish_in;
   logic [1:0]       lane;
   logic [2:0]       slen_cur;
   logic             accept;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   // Advance the byte-level item parser
   always_comb begin
      phase_in  = phase_ff;
      prefix_in = prefix_ff;
      data_in   = data_ff;
      remain_in = remain_ff;
      finish_in = 1'b0;
      slen_cur  = short_len(prefix_ff);
      lane      = 2'(slen_cur - remain_ff[2:0]);
      case (phase_ff)
         PH_SHORT: begin
            data_in   = data_ff | ({24'd0, req_chan.desc_byte} << {lane, 3'b000});
            remain_in = remain_ff - 8'd1;
            if (remain_in == 8'd0) begin
               finish_in = 1'b1;
               phase_in  = PH_PREFIX;
            end
         end
         PH_LONG_LEN: begin
            remain_in = req_chan.desc_byte;
            phase_in  = PH_LONG_TAG;
         end
         PH_LONG_TAG: begin
            phase_in = (remain_ff != 8'd0) ? PH_LONG_SKIP : PH_PREFIX;
         end
         PH_LONG_SKIP: begin
            if (remain_ff != 8'd0) remain_in = remain_ff - 8'd1;
            if (remain_in == 8'd0) phase_in = PH_PREFIX;
         end
         default: begin
            if (req_chan.desc_byte[7:4] == LONG_NIBBLE) begin
               phase_in = PH_LONG_LEN;
            end else begin
               prefix_in = req_chan.desc_byte;
               data_in   = 32'd0;
               remain_in = {5'd0, short_len(req_chan.desc_byte)};
               if (remain_in == 8'd0) begin
                  finish_in = 1'b1;
                  phase_in  = PH_PREFIX;
               end else begin
                  phase_in = PH_SHORT;
               end
            end
         end
      endcase
      // A descriptor cut short inside a short item still runs that item
      if (req_chan.last_byte && phase_in == PH_SHORT) finish_in = 1'b1;
   end

   // Item decode
   logic [1:0]  itype;
   logic [3:0]  itag;
   logic [1:0]  chk_k;
   logic [15:0] idx_w;
   logic [SW-1:0] rng_off;
   logic [SW-1:0] chk_off;
   logic [SW-1:0] shift_off [4];
   logic [1:0]  rng_k;
   logic [1:0]  lane_k;
   assign itype   = prefix_ff[3:2];
   assign itag    = prefix_ff[7:4];
   assign chk_k   = axis_of(rd_ff);
   assign idx_w   = range_target(t_ff) - rstart_ff;
   assign rng_off = sat(SW'(run_ff) + SW'(prod_ff));
   assign chk_off = sat(acc_ff);
   assign rng_k   = t_ff + 2'd1;
   assign lane_k  = chk_k - 2'd1;

   // Offsets moved past a report ID byte
   always_comb begin
      for (int i = 0; i < 4; i++) shift_off[i] = sat(SW'(off_ff[i]) + SW'(8));
   end

   // Sequencer: parse, execute items, scan the usage memory, emit the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_PREFIX;
         prefix_ff    <= 8'd0;
         data_ff      <= 32'd0;
         remain_ff    <= 8'd0;
         run_ff       <= '0;
         size_ff      <= 8'd0;
         count_ff     <= 16'd0;
         page_ff      <= 16'd0;
         fill_ff      <= '0;
         rstart_ff    <= 16'd0;
         rseen_ff     <= 1'b0;
         found_ff     <= 4'd0;
         rid_ff       <= 8'd0;
         for (int i = 0; i < 4; i++) begin
            off_ff[i]     <= '0;
            ax_bits_ff[i] <= 8'd0;
         end
         btn_bits_ff  <= 16'd0;
         sign_ff      <= 3'd0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  phase_ff  <= phase_in;
                  prefix_ff <= prefix_in;
                  data_ff   <= data_in;
                  remain_ff <= remain_in;
                  last_ff   <= req_chan.last_byte;
                  if (finish_in) state_ff <= S_EXEC;
                  else if (req_chan.last_byte) state_ff <= S_FINAL;
               end
            end
            S_EXEC: begin
               state_ff <= last_ff ? S_FINAL : S_IDLE;
               case (itype)
                  TYPE_MAIN: begin
                     if (itag == TAG_INPUT) begin
                        state_ff <= S_ADV;
                        if (page_ff == PAGE_BUTTON) begin
                           if (!found_ff[0] && count_ff != 16'd0 && size_ff == 8'd1) begin
                              off_ff[SLOT_BTN] <= run_ff;
                              btn_bits_ff      <= count_ff;
                              found_ff[0]      <= 1'b1;
                           end
                        end else if (page_ff == PAGE_DESKTOP) begin
                           u_ff     <= '0;
                           acc_ff   <= SW'(run_ff);
                           state_ff <= S_RD;
                        end
                     end
                  end
                  TYPE_GLOBAL: begin
                     if (itag == TAG_USAGE_PAGE) page_ff <= data_ff[15:0];
                     else if (itag == TAG_REPORT_SIZE)
                        size_ff <= (data_ff > 32'd255) ? 8'hFF : data_ff[7:0];
                     else if (itag == TAG_REPORT_CNT)
                        count_ff <= (data_ff > 32'd65535) ? 16'hFFFF : data_ff[15:0];
                     else if (itag == TAG_REPORT_ID) begin
                        if (found_ff[2:0] != 3'b111)
                           rid_ff <= (data_ff > 32'd255) ? 8'hFF : data_ff[7:0];
                     end
                  end
                  TYPE_LOCAL: begin
                     if (itag == TAG_USAGE) begin
                        if (fill_ff < SLOTS_F) begin
                           usage_mem[fill_ff[IW-1:0]] <= data_ff[15:0];
                           fill_ff <= fill_ff + FW'(1);
                        end
                     end else if (itag == TAG_USAGE_MIN) begin
                        rstart_ff <= data_ff[15:0];
                        rseen_ff  <= 1'b1;
                     end else if (itag == TAG_USAGE_MAX) begin
                        rseen_ff <= 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            // Read the next stored usage, or end the scan when none is left
            S_RD: begin
               if (u_ff < fill_ff) begin
                  rd_ff    <= usage_mem[u_ff[IW-1:0]];
                  state_ff <= S_CHK;
               end else if (fill_ff == '0 && rseen_ff) begin
                  t_ff     <= 2'd0;
                  state_ff <= S_RNG;
               end else begin
                  state_ff <= S_ADV;
               end
            end
            // Record an axis named by that usage
            S_CHK: begin
               if (chk_k != SLOT_BTN && !found_ff[chk_k]) begin
                  off_ff[chk_k]     <= chk_off[OW-1:0];
                  ax_bits_ff[chk_k] <= size_ff;
                  sign_ff[lane_k]   <= data_ff[1];
                  found_ff[chk_k]   <= 1'b1;
               end
               acc_ff   <= acc_ff + SW'(size_ff);
               u_ff     <= u_ff + FW'(1);
               state_ff <= S_RD;
            end
            // Position of one target inside the usage range
            S_RNG: begin
               idx_ok_ff <= (idx_w < count_ff);
               prod_ff   <= 24'(idx_w) * 24'(size_ff);
               state_ff  <= S_RNG2;
            end
            S_RNG2: begin
               if (idx_ok_ff && !found_ff[rng_k]) begin
                  off_ff[rng_k]     <= rng_off[OW-1:0];
                  ax_bits_ff[rng_k] <= size_ff;
                  sign_ff[t_ff]     <= data_ff[1];
                  found_ff[rng_k]   <= 1'b1;
               end
               t_ff     <= t_ff + 2'd1;
               state_ff <= (t_ff == 2'd2) ? S_ADV : S_RNG;
            end
            // Advance the bit offset past the Input item
            S_ADV: begin
               prod_ff  <= 24'(count_ff) * 24'(size_ff);
               state_ff <= S_ADV2;
            end
            S_ADV2: begin
               run_ff    <= rng_off[OW-1:0];
               fill_ff   <= '0;
               rstart_ff <= 16'd0;
               rseen_ff  <= 1'b0;
               state_ff  <= last_ff ? S_FINAL : S_IDLE;
            end
            // Form the response, shifting offsets past a report ID byte
            S_FINAL: begin
               for (int i = 0; i < 4; i++) begin
                  rsp_off_ff[i] <= (rid_ff != 8'd0) ?
                     shift_off[i][15:0] : 16'(SW'(off_ff[i]));
               end
               rsp_fmt_ff   <= (found_ff[2:0] == 3'b111);
               rsp_rid_ff   <= rid_ff;
               rsp_bbits_ff <= btn_bits_ff;
               rsp_xbits_ff <= ax_bits_ff[SLOT_X];
               rsp_ybits_ff <= ax_bits_ff[SLOT_Y];
               rsp_wbits_ff <= ax_bits_ff[SLOT_WHEEL];
               rsp_sign_ff  <= sign_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_OUT;
            end
            // Hold the response, then clear for the next descriptor
            S_OUT: begin
               if (rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
                  phase_ff     <= PH_PREFIX;
                  prefix_ff    <= 8'd0;
                  data_ff      <= 32'd0;
                  remain_ff    <= 8'd0;
                  run_ff       <= '0;
                  size_ff      <= 8'd0;
                  count_ff     <= 16'd0;
                  page_ff      <= 16'd0;
                  fill_ff      <= '0;
                  rstart_ff    <= 16'd0;
                  rseen_ff     <= 1'b0;
                  found_ff     <= 4'd0;
                  rid_ff       <= 8'd0;
                  for (int i = 0; i < 4; i++) begin
                     off_ff[i]     <= '0;
                     ax_bits_ff[i] <= 8'd0;
                  end
                  btn_bits_ff  <= 16'd0;
                  sign_ff      <= 3'd0;
                  last_ff      <= 1'b0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Drive the response channel
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.format_valid  = rsp_fmt_ff;
   assign rsp_chan.rpt_id        = rsp_rid_ff;
   assign rsp_chan.button_offset = rsp_off_ff[SLOT_BTN];
   assign rsp_chan.button_bits   = rsp_bbits_ff;
   assign rsp_chan.x_offset      = rsp_off_ff[SLOT_X];
   assign rsp_chan.x_bits        = rsp_xbits_ff;
   assign rsp_chan.y_offset      = rsp_off_ff[SLOT_Y];
   assign rsp_chan.y_bits        = rsp_ybits_ff;
   assign rsp_chan.wheel_offset  = rsp_off_ff[SLOT_WHEEL];
   assign rsp_chan.wheel_width   = rsp_wbits_ff;
   assign rsp_chan.signed_flags  = rsp_sign_ff;

   // Checks
   a_rsp_only_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_OUT)
      else $error("response valid outside output state");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= SLOTS_F)
      else $error("usage fill beyond memory depth");
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.last_byte |=> !req_chan.ready)
      else $error("request taken before the result was formed");
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      SW'(run_ff) <= OFF_MAX)
      else $error("bit offset beyond saturation limit");

endmodule
`default_nettype wire
